FILE: hw/rtl/assert_macros.svh
// assertion macros used by the allocator rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// property must hold at every rising clock edge outside reset
`define FBPA_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// expression must never be true outside reset
`define FBPA_ASSERT_NEVER(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define FBPA_ASSERT(label, clk, rst_n, prop, msg)
`define FBPA_ASSERT_NEVER(label, clk, rst_n, expr, msg)
`endif

`endif

FILE: hw/rtl/fbpa_pkg.sv
// types and constants of the fixed block pool allocator
package fbpa_pkg;

    localparam int ADDR_W        = 32;
    localparam int REQ_ALIGN_W   = 17;
    localparam int BLK_BYTES_W   = 17;
    localparam int BLK_ALIGN_W   = 13;
    localparam int FREE_W        = 11;
    localparam int APB_AW        = 4;
    localparam int APB_DW        = 32;
    localparam int SPAN_W        = ADDR_W + 1;
    localparam int MAX_REQ_BYTES = 65536;
    localparam int MAX_ALIGN     = 4096;

    typedef enum logic {
        CMD_ALLOC = 1'b0,
        CMD_FREE  = 1'b1
    } t_cmd;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_TOO_LARGE = 3'd1,
        ST_ALIGN     = 3'd2,
        ST_EMPTY     = 3'd3,
        ST_NULL      = 3'd4,
        ST_OVERFLOW  = 3'd5
    } t_status;

    typedef enum logic [1:0] {
        REG_REGION_BASE  = 2'd0,
        REG_REGION_BYTES = 2'd1,
        REG_BLOCK_BYTES  = 2'd2,
        REG_BLOCK_ALIGN  = 2'd3
    } t_reg_idx;

    typedef enum logic {
        OP_IDLE,
        OP_POP
    } t_op_state;

    typedef enum logic [2:0] {
        CFG_IDLE,
        CFG_ALIGN,
        CFG_CARVE,
        CFG_SPAN,
        CFG_CLIP,
        CFG_DIV
    } t_cfg_state;

    // pool geometry produced by a rebuild
    typedef struct packed {
        logic [ADDR_W-1:0]      start;
        logic [BLK_BYTES_W-1:0] bs;
        logic [BLK_ALIGN_W-1:0] align;
    } t_geom;

    typedef struct packed {
        logic busy;
        logic load;
    } t_pool_ctl;

endpackage

FILE: hw/rtl/fbpa_if.sv
// request and response channel interfaces of the allocator
interface fbpa_req_if import fbpa_pkg::*; ();
    logic                   valid;
    logic                   ready;
    t_cmd                   command;
    logic [ADDR_W-1:0]      request_bytes;
    logic [REQ_ALIGN_W-1:0] request_alignment;
    logic [ADDR_W-1:0]      block_address;

    modport source (output valid, command, request_bytes, request_alignment, block_address,
                    input ready);
    modport sink (input valid, command, request_bytes, request_alignment, block_address,
                  output ready);
endinterface

interface fbpa_rsp_if import fbpa_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              granted;
    t_status           status;
    logic [ADDR_W-1:0] address;
    logic [FREE_W-1:0] free_blocks;

    modport source (output valid, granted, status, address, free_blocks, input ready);
    modport sink (input valid, granted, status, address, free_blocks, output ready);
endinterface

FILE: hw/rtl/fixed_block_pool_allocator.sv
// fixed block pool allocator: free stack control around the stack ram
//
// Requests arrive on i_req (allocate or free), one response per request leaves
// on o_rsp; both are valid/ready channels, a transfer happens when both are high.
// Allocate checks size, then alignment, then an empty stack, and pops the top
// address; free ignores address zero, reports overflow on a full stack and
// otherwise pushes the address. Free and refused requests answer directly, a
// granted allocate first waits in OP_POP for the registered stack ram read; the
// response is registered, so the next request is taken in the cycle its result
// leaves or while the output register is empty. The stack lives in a MAX_BLOCKS
// deep ram; entries never pushed since the last rebuild are computed as start +
// (count - 1 - index) * block size, tracked by a low-water mark, so the ram needs
// no fill pass. Reset and every write on the APB port rebuild the pool geometry
// through ALIGN, CARVE, SPAN, CLIP and DIV (the serial block-count divider);
// requests are held off (ready low) until that is done. A stalled receiver keeps
// the response in the output register and holds off further requests.
module fixed_block_pool_allocator import fbpa_pkg::*; #(
    parameter int MAX_BLOCKS = 1024,
    parameter int LINK_BYTES = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    fbpa_req_if.sink          i_req,
    fbpa_rsp_if.source        o_rsp
);

    `include "assert_macros.svh"

    localparam int AW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int DW = $clog2(MAX_BLOCKS + 1);
    localparam int PW = DW + BLK_BYTES_W;
    localparam int SW = PW + ADDR_W;
    localparam int FW = DW + FREE_W;

    t_geom         geom;
    logic [DW-1:0] cfg_count;
    t_pool_ctl     ctl;

    t_op_state r_state;
    t_op_state n_state;

    logic [DW-1:0]     r_depth;
    logic [DW-1:0]     n_depth;
    logic [DW-1:0]     r_low;
    logic [DW-1:0]     n_low;
    logic [DW-1:0]     r_count;
    logic [PW-1:0]     r_prod;
    logic              r_calc;
    logic              r_out_valid;
    logic              n_out_valid;
    logic              r_out_granted;
    logic              n_out_granted;
    t_status           r_out_status;
    t_status           n_out_status;
    logic [ADDR_W-1:0] r_out_addr;
    logic [ADDR_W-1:0] n_out_addr;
    logic [FREE_W-1:0] r_out_free;

    logic              out_free;
    logic              accept;
    logic              out_load;
    logic              pop_start;
    logic              ram_we;
    logic              ram_re;
    logic [ADDR_W-1:0] ram_rdata;
    logic [DW-1:0]     depth_m1;
    logic [DW-1:0]     offs;
    logic [SW-1:0]     calc_sum;
    logic [ADDR_W-1:0] pop_addr;
    logic [FW-1:0]     free_wide;
    logic              too_large;
    logic              over_align;

    fbpa_cfg #(
        .MAX_BLOCKS (MAX_BLOCKS),
        .LINK_BYTES (LINK_BYTES)
    ) u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_geom  (geom),
        .o_count (cfg_count),
        .o_ctl   (ctl)
    );

    fbpa_ram #(
        .WIDTH (ADDR_W),
        .DEPTH (MAX_BLOCKS)
    ) u_stack (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_depth[AW-1:0]),
        .i_wdata (i_req.block_address),
        .i_re    (ram_re),
        .i_raddr (depth_m1[AW-1:0]),
        .o_rdata (ram_rdata)
    );

    assign out_free    = !r_out_valid || o_rsp.ready;
    assign i_req.ready = (r_state == OP_IDLE) && !ctl.busy && out_free;
    assign accept      = i_req.valid && i_req.ready;

    assign depth_m1   = r_depth - DW'(1);
    assign offs       = r_count - r_depth;
    assign too_large  = i_req.request_bytes > ADDR_W'(geom.bs);
    assign over_align = i_req.request_alignment > REQ_ALIGN_W'(geom.align);
    assign calc_sum   = SW'(geom.start) + SW'(r_prod);
    // below the low-water mark the entry still holds its carved address
    assign pop_addr   = r_calc ? calc_sum[ADDR_W-1:0] : ram_rdata;

    always_comb begin
        n_state       = r_state;
        n_depth       = r_depth;
        n_low         = r_low;
        out_load      = 1'b0;
        pop_start     = 1'b0;
        ram_we        = 1'b0;
        ram_re        = 1'b0;
        n_out_granted = 1'b0;
        n_out_status  = ST_OK;
        n_out_addr    = '0;
        unique case (r_state)
            OP_IDLE: begin
                if (accept) begin
                    if (i_req.command == CMD_ALLOC) begin
                        priority if (too_large) begin
                            out_load     = 1'b1;
                            n_out_status = ST_TOO_LARGE;
                        end else if (over_align) begin
                            out_load     = 1'b1;
                            n_out_status = ST_ALIGN;
                        end else if (r_depth == '0) begin
                            out_load     = 1'b1;
                            n_out_status = ST_EMPTY;
                        end else begin
                            ram_re    = 1'b1;
                            pop_start = 1'b1;
                            n_depth   = depth_m1;
                            n_low     = (depth_m1 < r_low) ? depth_m1 : r_low;
                            n_state   = OP_POP;
                        end
                    end else begin
                        out_load = 1'b1;
                        priority if (i_req.block_address == '0) begin
                            n_out_status = ST_NULL;
                        end else if (r_depth == DW'(MAX_BLOCKS)) begin
                            n_out_status = ST_OVERFLOW;
                        end else begin
                            ram_we        = 1'b1;
                            n_depth       = r_depth + DW'(1);
                            n_out_granted = 1'b1;
                        end
                    end
                end
            end
            OP_POP: begin
                out_load      = 1'b1;
                n_out_granted = 1'b1;
                n_out_addr    = pop_addr;
                n_state       = OP_IDLE;
            end
        endcase
        if (ctl.load) begin
            n_depth = cfg_count;
            n_low   = cfg_count;
        end
        if (out_load) begin
            n_out_valid = 1'b1;
        end else if (o_rsp.ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    assign free_wide = FW'(n_depth);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= OP_IDLE;
            r_depth     <= '0;
            r_low       <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_depth     <= n_depth;
            r_low       <= n_low;
            r_out_valid <= n_out_valid;
            if (ctl.load) begin
                r_count <= cfg_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop_start) begin
            r_calc <= depth_m1 < r_low;
            r_prod <= PW'(offs) * PW'(geom.bs);
        end
        if (out_load) begin
            r_out_granted <= n_out_granted;
            r_out_status  <= n_out_status;
            r_out_addr    <= n_out_addr;
            r_out_free    <= free_wide[FREE_W-1:0];
        end
    end

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.granted     = r_out_granted;
    assign o_rsp.status      = r_out_status;
    assign o_rsp.address     = r_out_addr;
    assign o_rsp.free_blocks = r_out_free;

    `FBPA_ASSERT(a_low_le_depth, i_clk, i_rst_n, r_low <= r_depth, "low-water mark above stack depth")
    `FBPA_ASSERT(a_pop_out_free, i_clk, i_rst_n, (r_state == OP_POP) |-> !r_out_valid, "pop with output register full")
    `FBPA_ASSERT(a_pop_result, i_clk, i_rst_n, (r_state == OP_POP) |=> (r_out_valid && r_out_granted), "pop did not produce a granted response")
    `FBPA_ASSERT_NEVER(a_busy_accept, i_clk, i_rst_n, ctl.busy && i_req.valid && i_req.ready, "request taken during pool rebuild")

endmodule

FILE: hw/rtl/fbpa_ram.sv
// generic single-write single-read ram with registered read data
module fbpa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hw/rtl/fbpa_div.sv
// serial restoring divider, one quotient bit per cycle
module fbpa_div #(
    parameter int NUM_W = 33,
    parameter int DEN_W = 17
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic             o_done,
    output logic [NUM_W-1:0] o_quot
);

    localparam int CW = $clog2(NUM_W + 1);

    logic             r_busy;
    logic             r_done;
    logic [CW-1:0]    r_cnt;
    logic [DEN_W-1:0] r_rem;
    logic [NUM_W-1:0] r_quot;

    logic [DEN_W:0]   rem_sh;
    logic             fits;
    logic [DEN_W:0]   rem_diff;

    always_comb begin
        rem_sh   = {r_rem, r_quot[NUM_W-1]};
        fits     = rem_sh >= {1'b0, i_den};
        rem_diff = fits ? (rem_sh - {1'b0, i_den}) : rem_sh;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= CW'(NUM_W);
        end else if (r_busy) begin
            r_cnt <= r_cnt - CW'(1);
            if (r_cnt == CW'(1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    // dividend bits shift out the top while quotient bits enter at the bottom
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= '0;
            r_quot <= i_num;
        end else if (r_busy) begin
            r_rem  <= rem_diff[DEN_W-1:0];
            r_quot <= {r_quot[NUM_W-2:0], fits};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

FILE: hw/rtl/fbpa_cfg.sv
// configuration registers and pool geometry rebuild sequencer
module fbpa_cfg import fbpa_pkg::*; #(
    parameter int MAX_BLOCKS = 1024,
    parameter int LINK_BYTES = 8,
    localparam int DW = $clog2(MAX_BLOCKS + 1)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    output t_geom             o_geom,
    output logic [DW-1:0]     o_count,
    output t_pool_ctl         o_ctl
);

    logic [ADDR_W-1:0]      r_region_base;
    logic [ADDR_W-1:0]      r_region_bytes;
    logic [BLK_BYTES_W-1:0] r_req_bytes;
    logic [BLK_ALIGN_W-1:0] r_blk_align;

    t_cfg_state r_state;
    t_cfg_state n_state;

    logic [BLK_ALIGN_W-1:0] r_align;
    logic [BLK_BYTES_W-1:0] r_req;
    logic [BLK_BYTES_W-1:0] r_bs;
    logic [SPAN_W-1:0]      r_start;
    logic [SPAN_W-1:0]      r_usable;
    logic [SPAN_W-1:0]      r_room;

    logic                   wr_en;
    t_reg_idx               reg_idx;
    logic [BLK_BYTES_W-1:0] req_clamp;
    logic [BLK_BYTES_W:0]   bs_sum;
    logic [BLK_BYTES_W:0]   bs_mask;
    logic [SPAN_W-1:0]      base_ext;
    logic [SPAN_W-1:0]      region_ext;
    logic [SPAN_W-1:0]      start_sum;
    logic [SPAN_W-1:0]      start_mask;
    logic [SPAN_W-1:0]      pad;
    logic [SPAN_W-1:0]      span_num;
    logic                   div_start;
    logic                   div_done;
    logic [SPAN_W-1:0]      div_quot;

    // smallest power of two at or above the register, within 1..4096
    function automatic logic [BLK_ALIGN_W-1:0] eff_align(input logic [BLK_ALIGN_W-1:0] v);
        logic [BLK_ALIGN_W-1:0] lim;
        logic [BLK_ALIGN_W-1:0] p;
        lim = v;
        if (lim == '0) begin
            lim = BLK_ALIGN_W'(1);
        end
        if (lim > BLK_ALIGN_W'(MAX_ALIGN)) begin
            lim = BLK_ALIGN_W'(MAX_ALIGN);
        end
        p = BLK_ALIGN_W'(MAX_ALIGN);
        for (int k = BLK_ALIGN_W - 1; k >= 0; k--) begin
            if ((BLK_ALIGN_W'(1) << k) >= lim) begin
                p = BLK_ALIGN_W'(1) << k;
            end
        end
        return p;
    endfunction

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = t_reg_idx'(paddr[3:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_region_base  <= '0;
            r_region_bytes <= '0;
            r_req_bytes    <= BLK_BYTES_W'(64);
            r_blk_align    <= BLK_ALIGN_W'(8);
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_REGION_BASE:  r_region_base  <= pwdata;
                REG_REGION_BYTES: r_region_bytes <= pwdata;
                REG_BLOCK_BYTES:  r_req_bytes    <= pwdata[BLK_BYTES_W-1:0];
                REG_BLOCK_ALIGN:  r_blk_align    <= pwdata[BLK_ALIGN_W-1:0];
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_REGION_BASE:  prdata = r_region_base;
            REG_REGION_BYTES: prdata = r_region_bytes;
            REG_BLOCK_BYTES:  prdata = APB_DW'(r_req_bytes);
            REG_BLOCK_ALIGN:  prdata = APB_DW'(r_blk_align);
        endcase
    end

    // rebuild datapath
    always_comb begin
        req_clamp = r_req_bytes;
        if (r_req_bytes > BLK_BYTES_W'(MAX_REQ_BYTES)) begin
            req_clamp = BLK_BYTES_W'(MAX_REQ_BYTES);
        end
        if (req_clamp < BLK_BYTES_W'(LINK_BYTES)) begin
            req_clamp = BLK_BYTES_W'(LINK_BYTES);
        end
        bs_mask    = ~((BLK_BYTES_W + 1)'(r_align) - (BLK_BYTES_W + 1)'(1));
        bs_sum     = ((BLK_BYTES_W + 1)'(r_req) + (BLK_BYTES_W + 1)'(r_align)
                      - (BLK_BYTES_W + 1)'(1)) & bs_mask;
        base_ext   = {1'b0, r_region_base};
        region_ext = {1'b0, r_region_bytes};
        start_mask = ~(SPAN_W'(r_align) - SPAN_W'(1));
        start_sum  = (base_ext + SPAN_W'(r_align) - SPAN_W'(1)) & start_mask;
        pad        = r_start - base_ext;
        span_num   = (r_usable > r_room) ? r_room : r_usable;
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            CFG_ALIGN: begin
                r_align <= eff_align(r_blk_align);
                r_req   <= req_clamp;
            end
            CFG_CARVE: begin
                r_bs    <= bs_sum[BLK_BYTES_W-1:0];
                r_start <= start_sum;
            end
            CFG_SPAN: begin
                r_usable <= (region_ext > pad) ? (region_ext - pad) : '0;
                // blocks must end at or below the top of the address space
                r_room   <= r_start[ADDR_W] ? '0 : ({1'b1, {ADDR_W{1'b0}}} - r_start);
            end
            CFG_IDLE, CFG_CLIP, CFG_DIV: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= CFG_ALIGN;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state   = r_state;
        div_start = 1'b0;
        o_ctl     = '{busy: 1'b1, load: 1'b0};
        unique case (r_state)
            CFG_IDLE: begin
                o_ctl.busy = 1'b0;
            end
            CFG_ALIGN: n_state = CFG_CARVE;
            CFG_CARVE: n_state = CFG_SPAN;
            CFG_SPAN:  n_state = CFG_CLIP;
            CFG_CLIP: begin
                div_start = 1'b1;
                n_state   = CFG_DIV;
            end
            CFG_DIV: begin
                if (div_done) begin
                    o_ctl.load = 1'b1;
                    n_state    = CFG_IDLE;
                end
            end
        endcase
        // any register write starts the rebuild over
        if (wr_en) begin
            o_ctl.load = 1'b0;
            n_state    = CFG_ALIGN;
        end
    end

    fbpa_div #(
        .NUM_W (SPAN_W),
        .DEN_W (BLK_BYTES_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (span_num),
        .i_den   (r_bs),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    assign o_count = (div_quot > SPAN_W'(MAX_BLOCKS)) ? DW'(MAX_BLOCKS) : div_quot[DW-1:0];
    assign o_geom  = '{start: r_start[ADDR_W-1:0], bs: r_bs, align: r_align};

endmodule

FILE: test/tb_top.sv
// testbench for the fixed block pool allocator: directed and random allocate/free traffic
module tb_top import fbpa_pkg::*; ();

    localparam int POOL_MAX    = 1024;
    localparam int LINK_SIZE   = 8;
    localparam int QUIET_LIMIT = 5000;
    localparam int PHASE_ITEMS = 210;
    localparam int HOLD_AT     = 500;
    localparam int LONG_HOLD   = 300;

    typedef struct {
        t_cmd                   command;
        logic [ADDR_W-1:0]      req_bytes;
        logic [REQ_ALIGN_W-1:0] req_align;
        logic [ADDR_W-1:0]      blk_addr;
    } t_pool_req;

    typedef struct {
        logic              granted;
        t_status           status;
        logic [ADDR_W-1:0] address;
        logic [FREE_W-1:0] free_blocks;
    } t_pool_rsp;

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    fbpa_req_if req_if ();
    fbpa_rsp_if rsp_if ();

    fixed_block_pool_allocator #(
        .MAX_BLOCKS(POOL_MAX),
        .LINK_BYTES(LINK_SIZE)
    ) DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // pool model: register copies, derived geometry and the free stack
    logic [31:0] cfg_base;
    logic [31:0] cfg_bytes;
    logic [16:0] cfg_req;
    logic [12:0] cfg_align;
    int unsigned blk_bytes;
    int unsigned blk_align;
    int          blk_align_lg;
    logic [31:0] pool_start;
    int unsigned pool_count;
    int unsigned pool_depth;
    logic [31:0] pool_stack [POOL_MAX];

    t_pool_req request_q[$];
    t_pool_rsp outcome_q[$];
    t_pool_req req_cur;
    t_pool_rsp want;
    logic      req_busy = 1'b0;
    int        send_gap = 0;
    int        rsp_hold = 0;
    logic      long_hold_done = 1'b0;
    int        send_gap_pct = 0;
    int        rsp_stall_pct = 0;
    int        alloc_pct = 50;
    int        responses_seen = 0;
    int        mismatches = 0;
    int        quiet_cycles = 0;

    function automatic void carve_pool();
        longint unsigned r, v, a, bs, start, pad, usable, room, cnt;
        int lg;
        r = cfg_req;
        if (r > MAX_REQ_BYTES) r = MAX_REQ_BYTES;
        if (r < LINK_SIZE) r = LINK_SIZE;
        v = cfg_align;
        if (v == 0) v = 1;
        if (v > MAX_ALIGN) v = MAX_ALIGN;
        a = 1;
        lg = 0;
        while (a < v) begin
            a = a << 1;
            lg++;
        end
        bs = (r + a - 1) & ~(a - 1);
        start = cfg_base;
        start = (start + a - 1) & ~(a - 1);
        pad = start - cfg_base;
        usable = (cfg_bytes > pad) ? cfg_bytes - pad : 0;
        // blocks must end at or below the top of the address space
        room = (start < 64'h1_0000_0000) ? 64'h1_0000_0000 - start : 0;
        if (usable > room) usable = room;
        cnt = usable / bs;
        if (cnt > POOL_MAX) cnt = POOL_MAX;
        for (int i = 0; i < cnt; i++) begin
            pool_stack[i] = 32'(start + (cnt - 1 - i) * bs);
        end
        blk_bytes = 32'(bs);
        blk_align = 32'(a);
        blk_align_lg = lg;
        pool_start = 32'(start);
        pool_count = 32'(cnt);
        pool_depth = 32'(cnt);
    endfunction

    function automatic t_pool_rsp serve_request(t_pool_req r);
        t_pool_rsp o;
        o = '{1'b0, ST_OK, '0, '0};
        if (r.command == CMD_ALLOC) begin
            if (r.req_bytes > blk_bytes) begin
                o.status = ST_TOO_LARGE;
            end else if (r.req_align > blk_align) begin
                o.status = ST_ALIGN;
            end else if (pool_depth == 0) begin
                o.status = ST_EMPTY;
            end else begin
                pool_depth--;
                o.address = pool_stack[pool_depth];
                o.granted = 1'b1;
            end
        end else begin
            if (r.blk_addr == '0) begin
                o.status = ST_NULL;
            end else if (pool_depth >= POOL_MAX) begin
                o.status = ST_OVERFLOW;
            end else begin
                pool_stack[pool_depth] = r.blk_addr;
                pool_depth++;
                o.granted = 1'b1;
            end
        end
        o.free_blocks = FREE_W'(pool_depth);
        return o;
    endfunction

    function automatic int next_gap(int pct);
        if ($urandom_range(99) >= pct) return 0;
        return ($urandom_range(9) == 0) ? $urandom_range(30, 8) : $urandom_range(2, 1);
    endfunction

    function automatic t_pool_req random_request();
        t_pool_req r;
        int unsigned pick;
        r.command   = ($urandom_range(99) < alloc_pct) ? CMD_ALLOC : CMD_FREE;
        r.req_bytes = $urandom;
        r.req_align = REQ_ALIGN_W'($urandom);
        r.blk_addr  = $urandom;
        pick = $urandom_range(99);
        if (r.command == CMD_ALLOC) begin
            if (pick < 85) begin
                r.req_bytes = $urandom_range(blk_bytes);
                r.req_align = (pick < 15) ? '0
                            : REQ_ALIGN_W'(1) << $urandom_range(blk_align_lg);
            end else if (pick < 92) begin
                r.req_bytes = blk_bytes + 1;
            end else if (pick < 96) begin
                r.req_bytes = $urandom_range(blk_bytes);
                r.req_align = REQ_ALIGN_W'(blk_align * 2);
            end
        end else begin
            if (pick < 90 && pool_count > 0) begin
                r.blk_addr = pool_start + $urandom_range(pool_count - 1) * blk_bytes;
            end else if (pick < 95) begin
                r.blk_addr = '0;
            end
        end
        return r;
    endfunction

    task automatic push_alloc(input logic [31:0] nbytes, input logic [16:0] nalign);
        t_pool_req r;
        r = '{CMD_ALLOC, nbytes, nalign, $urandom};
        request_q.push_back(r);
    endtask

    task automatic push_free(input logic [31:0] addr);
        t_pool_req r;
        r = '{CMD_FREE, $urandom, REQ_ALIGN_W'($urandom), addr};
        request_q.push_back(r);
    endtask

    task automatic wait_drained();
        do @(negedge i_clk);
        while (request_q.size() != 0 || req_busy || outcome_q.size() != 0);
    endtask

    // only called with the pool idle; each write rebuilds the pool
    task automatic apb_write(input t_reg_idx idx, input logic [APB_DW-1:0] value);
        @(posedge i_clk);
        @(posedge i_clk);
        while (!req_if.ready) @(posedge i_clk);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk);
        while (!pready);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_REGION_BASE:  cfg_base  = value;
            REG_REGION_BYTES: cfg_bytes = value;
            REG_BLOCK_BYTES:  cfg_req   = value[16:0];
            REG_BLOCK_ALIGN:  cfg_align = value[12:0];
            default: ;
        endcase
        carve_pool();
    endtask

    task automatic setup_pool(input logic [31:0] base, input logic [31:0] nbytes,
                              input logic [31:0] req, input logic [31:0] align);
        apb_write(REG_BLOCK_BYTES, req);
        apb_write(REG_BLOCK_ALIGN, align);
        apb_write(REG_REGION_BASE, base);
        apb_write(REG_REGION_BYTES, nbytes);
    endtask

    task automatic run_random_phase(input int ph);
        logic [31:0] req, align, base, nbytes;
        int unsigned pick;
        pick = $urandom_range(99);
        if (ph == 0) begin
            req   = $urandom_range(64, 1);
            align = 8;
        end else if (ph == 1) begin
            req   = $urandom_range(2048, 1);
            align = 32'(1) << $urandom_range(8);
        end else begin
            if (pick < 70) req = $urandom_range(128, 1);
            else if (pick < 90) req = $urandom_range(65536, 1);
            else req = $urandom_range(17'h1FFFF);
            align = ($urandom_range(99) < 70) ? 32'(1) << $urandom_range(12)
                                               : $urandom_range(13'h1FFF);
        end
        apb_write(REG_BLOCK_BYTES, req);
        apb_write(REG_BLOCK_ALIGN, align);
        // for ph above 1 the region length is picked from the block size the model now holds
        if (ph == 0) begin
            base   = $urandom_range(255);
            nbytes = '1;
        end else if (ph == 1) begin
            base   = {16'hFFFF, 16'($urandom)};
            nbytes = '1;
        end else begin
            base   = $urandom;
            nbytes = ($urandom_range(9) == 0) ? $urandom
                   : $urandom_range(48) * blk_bytes + $urandom_range(blk_bytes);
        end
        apb_write(REG_REGION_BASE, base);
        apb_write(REG_REGION_BYTES, nbytes);
        send_gap_pct  = (ph == 0) ? 0 : $urandom_range(40);
        rsp_stall_pct = (ph == 0) ? 0 : $urandom_range(30);
        alloc_pct     = (ph == 0) ? 35 : $urandom_range(65, 35);
        for (int k = 0; k < PHASE_ITEMS; k++) begin
            // in phase 4 the sender stops halfway until the block has answered everything so far
            if (ph == 4 && k == PHASE_ITEMS / 2) wait_drained();
            request_q.push_back(random_request());
        end
        wait_drained();
    endtask

    // request side: present one transfer at a time, random gaps between them
    always @(negedge i_clk) begin
        if (i_rst_n && !req_busy && send_gap == 0 && request_q.size() != 0) begin
            req_cur  = request_q.pop_front();
            req_busy = 1'b1;
            send_gap = next_gap(send_gap_pct);
            req_if.valid             <= 1'b1;
            req_if.command           <= req_cur.command;
            req_if.request_bytes     <= req_cur.req_bytes;
            req_if.request_alignment <= req_cur.req_align;
            req_if.block_address     <= req_cur.blk_addr;
        end else if (!req_busy) begin
            req_if.valid <= 1'b0;
            if (send_gap > 0) send_gap--;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && req_if.valid && req_if.ready) begin
            outcome_q.push_back(serve_request(req_cur));
            req_busy = 1'b0;
        end
    end

    // response side: random stalls plus one long hold so the block backs up
    always @(negedge i_clk) begin
        if (!long_hold_done && responses_seen >= HOLD_AT) begin
            long_hold_done = 1'b1;
            rsp_hold = LONG_HOLD;
        end
        if (rsp_hold == 0) rsp_hold = next_gap(rsp_stall_pct);
        if (rsp_hold > 0) begin
            rsp_hold--;
            rsp_if.ready <= 1'b0;
        end else begin
            rsp_if.ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            responses_seen++;
            if (outcome_q.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected result, expected none, actual granted=%0b status=%0d",
                         $time, rsp_if.granted, rsp_if.status);
            end else begin
                want = outcome_q.pop_front();
                if (rsp_if.granted !== want.granted || rsp_if.status !== want.status ||
                    rsp_if.address !== want.address ||
                    rsp_if.free_blocks !== want.free_blocks) begin
                    mismatches++;
                    $display("%0t: expected granted=%0b status=%0d address=%h free=%0d",
                             $time, want.granted, want.status, want.address,
                             want.free_blocks);
                    $display("%0t:   actual granted=%0b status=%0d address=%h free=%0d",
                             $time, rsp_if.granted, rsp_if.status, rsp_if.address,
                             rsp_if.free_blocks);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
            (psel && penable)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    initial begin
        i_rst_n                  = 1'b0;
        psel                     = 1'b0;
        penable                  = 1'b0;
        pwrite                   = 1'b0;
        paddr                    = '0;
        pwdata                   = '0;
        req_if.valid             = 1'b0;
        req_if.command           = CMD_ALLOC;
        req_if.request_bytes     = '0;
        req_if.request_alignment = '0;
        req_if.block_address     = '0;
        rsp_if.ready             = 1'b0;
        cfg_base  = 32'd0;
        cfg_bytes = 32'd0;
        cfg_req   = 17'd64;
        cfg_align = 13'd8;
        carve_pool();
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        send_gap_pct  = 20;
        rsp_stall_pct = 15;
        // pool after reset has no blocks
        push_alloc(32'd0, 17'd0);
        push_alloc('1, 17'd0);
        push_alloc(32'd64, '1);
        push_alloc(32'd65, 17'd16);
        push_free(32'd0);
        push_free('1);
        push_alloc(32'd64, 17'd8);
        push_alloc(32'd64, 17'd8);
        wait_drained();

        // full stack with a block at address zero
        setup_pool(32'd0, '1, 32'd8, 32'd8);
        push_free(32'h1234);
        push_alloc(32'd8, 17'd8);
        push_free(32'd0);
        push_alloc(32'd0, 17'd0);
        wait_drained();

        // size register zero, alignment clamped, aligned start wraps past the top
        setup_pool(32'hFFFF_F001, '1, 32'd0, 32'h1FFF);
        push_alloc(32'd4096, 17'd4096);
        push_alloc(32'd4097, 17'd0);
        wait_drained();

        // oversize request register, odd alignment, region end clipped at the top
        setup_pool(32'hFFFE_0003, '1, 32'h1FFFF, 32'd3000);
        push_alloc(32'd65536, 17'd4096);
        push_alloc(32'd1, 17'd1);
        wait_drained();

        // unaligned base with alignment one, a handful of blocks
        setup_pool(32'h1000_0005, 32'd100, 32'd24, 32'd1);
        repeat (5) push_alloc(32'd24, 17'd1);
        push_free(32'h55);
        wait_drained();

        for (int ph = 0; ph < 7; ph++) begin
            run_random_phase(ph);
        end

        wait_drained();
        repeat (20) @(posedge i_clk);
        if (mismatches == 0 && outcome_q.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+hw/rtl
hw/rtl/fbpa_pkg.sv
hw/rtl/fbpa_if.sv
hw/rtl/fbpa_ram.sv
hw/rtl/fbpa_div.sv
hw/rtl/fbpa_cfg.sv
hw/rtl/fixed_block_pool_allocator.sv
test/tb_top.sv
